// ----- src/mf3_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared constants, types and the compare-exchange helper of the 3x3 median
// filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int PIXEL_BITS = 8;
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int W_BITS     = 11;
   localparam int H_BITS     = 16;
   localparam int ROW_BITS   = H_BITS + 1;
   localparam int CSR_BITS   = 16;
   localparam int LINE_BITS  = 2 * PIXEL_BITS;

   // register indexes of the csr port
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   typedef logic [PIXEL_BITS-1:0] pixel_type;
   typedef pixel_type             win_type [9];

   typedef struct packed {
      logic valid;
      logic frame_last;
   } mf3_ctl_type;

   // returns {min, max}
   function automatic logic [LINE_BITS-1:0] cas(input pixel_type a, input pixel_type b);
      return (a > b) ? {b, a} : {a, b};
   endfunction

endpackage

// ----- src/mf3_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_ram
// Generic single-clock RAM, one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module mf3_ram #(
   parameter int DATA_WIDTH = 16,
   parameter int DEPTH      = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0]    wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0]    rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/mf3_median9.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_median9
// Two-stage median-of-nine sorting network with its output register.
// ----------------------------------------------------------------------------
module mf3_median9
   import mf3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  mf3_ctl_type in_ctl,
   input  win_type     in_win,
   output mf3_ctl_type out_ctl,
   output pixel_type   out_median
);

   win_type     a_win_in;
   win_type     a_win_ff;
   mf3_ctl_type a_ctl_ff;
   pixel_type   median_in;
   pixel_type   median_ff;
   mf3_ctl_type out_ctl_ff;

   // stage a: sort each triple
   always_comb begin
      win_type p;
      p = in_win;
      {p[1], p[2]} = cas(p[1], p[2]);
      {p[4], p[5]} = cas(p[4], p[5]);
      {p[7], p[8]} = cas(p[7], p[8]);
      {p[0], p[1]} = cas(p[0], p[1]);
      {p[3], p[4]} = cas(p[3], p[4]);
      {p[6], p[7]} = cas(p[6], p[7]);
      {p[1], p[2]} = cas(p[1], p[2]);
      {p[4], p[5]} = cas(p[4], p[5]);
      {p[7], p[8]} = cas(p[7], p[8]);
      a_win_in = p;
   end

   // stage b: merge the sorted triples down to the middle value
   always_comb begin
      win_type p;
      p = a_win_ff;
      {p[0], p[3]} = cas(p[0], p[3]);
      {p[5], p[8]} = cas(p[5], p[8]);
      {p[4], p[7]} = cas(p[4], p[7]);
      {p[3], p[6]} = cas(p[3], p[6]);
      {p[1], p[4]} = cas(p[1], p[4]);
      {p[2], p[5]} = cas(p[2], p[5]);
      {p[4], p[7]} = cas(p[4], p[7]);
      {p[4], p[2]} = cas(p[4], p[2]);
      {p[6], p[4]} = cas(p[6], p[4]);
      {p[4], p[2]} = cas(p[4], p[2]);
      median_in = p[4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff   <= '0;
         out_ctl_ff <= '0;
      end else if (advance) begin
         a_ctl_ff   <= in_ctl;
         out_ctl_ff <= a_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_win_ff  <= a_win_in;
         median_ff <= median_in;
      end
   end

   assign out_ctl    = out_ctl_ff;
   assign out_median = median_ff;

endmodule

// ----- src/median_filter_3x3_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_3x3_top
// Streaming 3x3 median filter over a zero-padded raster image.
// ----------------------------------------------------------------------------
// Pixels enter on the req_ channel in raster order, one beat per pixel;
// req_tuser marks a flush beat, taken as a zero pixel. After a frame the
// source sends image_width+1 flush beats so that the last row drains.
// The median of pixel (r,c) leaves on rsp_ with the beat that carries
// pixel (r+1,c+1), or (r+2,0) for the last column; the first width+1
// beats of a frame give no result. rsp_tlast marks the frame's last pixel,
// after which the next beat starts a new frame.
// Throughput is one beat per clock. An accepted beat is taken into the
// read-stage registers with its line-store read (one RAM holds both
// previous rows, read and rewritten at the column address, with a bypass
// for back-to-back access of the same column); the first sorting stage
// then fills the stage-a register, and the rest of the network the
// output register that drives rsp_. While a result waits on a low
// rsp_tready the whole pipe holds and req_tready drops in the same cycle.
// Reset or any csr write restarts the frame; the line store needs no clearing
// since rows before the frame start are masked to zero. The user must make
// csr writes only while the pipe is empty; the block does not enforce it.
// ----------------------------------------------------------------------------
module median_filter_3x3_top
   import mf3_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // csr port
   input  logic                csr_wr_en,
   input  logic                csr_index,
   input  logic [CSR_BITS-1:0] csr_wr_data,
   // input stream
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] pixel
   input  logic                req_tuser,   // flush
   // result stream
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // [7:0] median
   output logic                rsp_tlast    // frame_last
);

   logic [W_BITS-1:0]    width_ff;
   logic [H_BITS-1:0]    height_ff;
   logic [W_BITS-1:0]    w_eff;
   logic [H_BITS-1:0]    h_eff;
   logic [ROW_BITS-1:0]  h_end;
   logic [COL_BITS-1:0]  ci_ff;
   logic [ROW_BITS-1:0]  ri_ff;
   logic [COL_BITS-1:0]  ci_cur;
   logic [W_BITS-1:0]    ci_inc;
   logic                 wrap;
   logic [ROW_BITS-1:0]  ri_inc;
   logic                 adv;
   logic                 accept;
   pixel_type            x;
   logic                 emit;
   logic                 is_last;

   logic                 s1_valid_ff;
   logic [COL_BITS-1:0]  s1_addr_ff;
   pixel_type            s1_x_ff;
   logic                 s1_emit_ff;
   logic                 s1_last_ff;
   logic                 s1_top_ok_ff;
   logic                 s1_mid_ok_ff;
   logic                 s1_left_ok_ff;
   logic                 s1_right_ok_ff;
   logic                 s1_fwd_ff;
   logic [LINE_BITS-1:0] fwd_data_ff;

   logic                 ram_wr_en;
   logic [LINE_BITS-1:0] ram_wr_data;
   logic [LINE_BITS-1:0] ram_rd_data;
   logic [LINE_BITS-1:0] line_rd;
   pixel_type            col [3];
   pixel_type            lcol_ff [3];
   pixel_type            mcol_ff [3];
   win_type              win;
   mf3_ctl_type          sort_ctl;
   mf3_ctl_type          out_ctl;
   pixel_type            out_median;

   // effective frame size
   always_comb begin
      priority if (width_ff == '0) begin
         w_eff = W_BITS'(1);
      end else if (width_ff > W_BITS'(MAX_WIDTH)) begin
         w_eff = W_BITS'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
   end

   assign h_eff = (height_ff == '0) ? H_BITS'(1) : height_ff;
   assign h_end = {1'b0, h_eff} + ROW_BITS'(1);

   assign adv        = !out_ctl.valid || rsp_tready;
   assign req_tready = adv;
   assign accept     = req_tvalid && adv;

   // position and classification of the incoming beat
   assign ci_cur  = ({1'b0, ci_ff} >= w_eff) ? '0 : ci_ff;
   assign x       = (req_tuser || ri_ff >= {1'b0, h_eff}) ? '0 : req_tdata[PIXEL_BITS-1:0];
   assign emit    = (ri_ff >= ROW_BITS'(2)) || (ri_ff == ROW_BITS'(1) && ci_cur != '0);
   assign is_last = (ci_cur == '0) && (ri_ff == h_end);
   assign ci_inc  = {1'b0, ci_cur} + W_BITS'(1);
   assign wrap    = (ci_inc >= w_eff);

   always_comb begin
      ri_inc = wrap ? ri_ff + ROW_BITS'(1) : ri_ff;
      if (ri_inc > h_end) begin
         ri_inc = h_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= W_BITS'(1024);
         height_ff <= H_BITS'(1024);
         ci_ff     <= '0;
         ri_ff     <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wr_data[W_BITS-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wr_data[H_BITS-1:0];
            default:          width_ff  <= width_ff;
         endcase
         ci_ff <= '0;
         ri_ff <= '0;
      end else if (accept) begin
         if (is_last) begin
            ci_ff <= '0;
            ri_ff <= '0;
         end else begin
            ci_ff <= wrap ? '0 : ci_inc[COL_BITS-1:0];
            ri_ff <= ri_inc;
         end
      end
   end

   // read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_addr_ff     <= ci_cur;
         s1_x_ff        <= x;
         s1_emit_ff     <= emit;
         s1_last_ff     <= is_last;
         s1_top_ok_ff   <= (ri_ff >= ROW_BITS'(2));
         s1_mid_ok_ff   <= (ri_ff >= ROW_BITS'(1));
         s1_left_ok_ff  <= (ci_cur == '0) ? (w_eff >= W_BITS'(2)) : (ci_cur >= COL_BITS'(2));
         s1_right_ok_ff <= (ci_cur != '0);
         // same column rewritten in this cycle: the RAM read returns stale data
         s1_fwd_ff      <= s1_valid_ff && (s1_addr_ff == ci_cur);
         fwd_data_ff    <= ram_wr_data;
      end
   end

   // line store entry: [15:8] older row, [7:0] newer row
   mf3_ram #(
      .DATA_WIDTH (LINE_BITS),
      .DEPTH      (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (ci_cur),
      .rd_data (ram_rd_data)
   );

   assign line_rd     = s1_fwd_ff ? fwd_data_ff : ram_rd_data;
   assign ram_wr_en   = adv && s1_valid_ff;
   assign ram_wr_data = {line_rd[PIXEL_BITS-1:0], s1_x_ff};

   assign col[0] = s1_top_ok_ff ? line_rd[LINE_BITS-1:PIXEL_BITS] : '0;
   assign col[1] = s1_mid_ok_ff ? line_rd[PIXEL_BITS-1:0] : '0;
   assign col[2] = s1_x_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win[k]     = s1_left_ok_ff ? lcol_ff[k] : '0;
         win[3 + k] = mcol_ff[k];
         win[6 + k] = s1_right_ok_ff ? col[k] : '0;
      end
   end

   // sliding window columns
   always_ff @(posedge clock) begin
      if (reset || csr_wr_en) begin
         for (int k = 0; k < 3; k++) begin
            lcol_ff[k] <= '0;
            mcol_ff[k] <= '0;
         end
      end else if (adv && s1_valid_ff) begin
         for (int k = 0; k < 3; k++) begin
            lcol_ff[k] <= s1_last_ff ? '0 : mcol_ff[k];
            mcol_ff[k] <= s1_last_ff ? '0 : col[k];
         end
      end
   end

   assign sort_ctl.valid      = s1_valid_ff && s1_emit_ff;
   assign sort_ctl.frame_last = s1_last_ff;

   mf3_median9 u_median9 (
      .clock      (clock),
      .reset      (reset),
      .advance    (adv),
      .in_ctl     (sort_ctl),
      .in_win     (win),
      .out_ctl    (out_ctl),
      .out_median (out_median)
   );

   assign rsp_tvalid = out_ctl.valid;
   assign rsp_tlast  = out_ctl.frame_last;
   assign rsp_tdata  = out_median;

   // frame end puts the position back to the origin
   a_last_restart: assert property (@(posedge clock) disable iff (reset)
      accept && is_last |=> (ci_ff == '0) && (ri_ff == '0))
      else $error("position not cleared after frame end");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      ri_ff <= h_end)
      else $error("row count beyond frame end");

   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, ci_ff} < w_eff)
      else $error("column count beyond image width");

endmodule
